>>> design/urc_pkg.sv
// ----------------------------------------------------------------------------
// urc_pkg
// Types and constants shared by the ultrasonic range controller files.
// ----------------------------------------------------------------------------
`default_nettype none

package urc_pkg;

    localparam int unsigned THRESH_W   = 11;
    localparam int unsigned TIMEOUT_W  = 16;
    localparam int unsigned SUBCM_W    = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [TIMEOUT_W-1:0] TRIG_LOW_TICKS  = 16'd2;
    localparam logic [TIMEOUT_W-1:0] TRIG_HIGH_TICKS = 16'd10;
    localparam logic [SUBCM_W-1:0]   US_PER_CM_LAST  = 6'd57;
    localparam logic [THRESH_W-1:0]  CM_MAX          = 11'd2047;

    localparam logic [THRESH_W-1:0]  THRESHOLD_RESET = 11'd0;
    localparam logic [TIMEOUT_W-1:0] GUARD_RESET     = 16'd2000;
    localparam logic [TIMEOUT_W-1:0] ECHO_RESET      = 16'd20000;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO      = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_GUARD = 3'd1,
        PH_TLOW  = 3'd2,
        PH_THIGH = 3'd3,
        PH_WEND  = 3'd4,
        PH_WRISE = 3'd5,
        PH_MEAS  = 3'd6
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic echo;
    } sample_t;

    typedef struct packed {
        logic                trig;
        logic                busy_res;
        logic                done_res;
        logic [THRESH_W-1:0] distance_cm;
        logic                no_echo;
        logic                obstacle;
    } result_t;

endpackage

`default_nettype wire

>>> design/urc_if.sv
// ----------------------------------------------------------------------------
// urc_sample_if / urc_result_if
// Valid/ready channels for tick samples and tick results.
// ----------------------------------------------------------------------------
`default_nettype none

interface urc_sample_if
    import urc_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface urc_result_if
    import urc_pkg::*;
;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/ultrasonic_range_controller.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_controller
// Trigger/echo sequencer for an ultrasonic rangefinder, one beat per tick.
// ----------------------------------------------------------------------------
// usage:
//   samples : one beat per microsecond tick, carrying start_req and the
//             sampled echo level
//   results : exactly one beat per sample beat, in order: trigger level,
//             busy, done, distance in centimetres, no-echo and obstacle flags
//   cfg_*   : write port for threshold_cm (0), guard_timeout_us (1) and
//             echo_timeout_us (2); writes apply at once, other indexes ignored
// output: the result of a sample is registered and appears on the results
//   channel in the cycle after the sample beat; the sequencer state and the
//   result register are updated at the same edge
// throughput: one sample per cycle when not stalled; the centimetre divide
//   is a running modulo-58 counter: each tick is a short increment and compare
// stall: samples.ready falls only while a result is held and results.ready
//   is low; the held result stays until taken
// reset: phase idle, counters cleared, threshold 0, guard 2000, echo 20000,
//   result register empty
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_controller
    import urc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    urc_sample_if.sink                 samples,
    urc_result_if.source               results
);

    phase_t               phase_reg, phase_next;
    logic [TIMEOUT_W-1:0] timer_reg, timer_next;
    logic [SUBCM_W-1:0]   sub_cm_reg, sub_cm_next;
    logic [THRESH_W-1:0]  cm_reg, cm_next;

    logic [THRESH_W-1:0]  threshold_reg;
    logic [TIMEOUT_W-1:0] guard_reg;
    logic [TIMEOUT_W-1:0] echo_to_reg;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, res_next;
    logic    accept;

    assign samples.ready = !out_valid_reg || results.ready;
    assign accept        = samples.valid && samples.ready;
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            guard_reg     <= GUARD_RESET;
            echo_to_reg   <= ECHO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[THRESH_W-1:0];
                CFG_GUARD:     guard_reg     <= cfg_data;
                CFG_ECHO:      echo_to_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // next state and tick result
    always_comb
    begin
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        sub_cm_next = sub_cm_reg;
        cm_next     = cm_reg;
        res_next    = '0;

        case (phase_reg)
            PH_GUARD:
            begin
                if (!samples.data.echo || timer_reg >= guard_reg)
                begin
                    phase_next = PH_TLOW;
                    timer_next = '0;
                end
                else
                begin
                    timer_next = timer_reg + 1'b1;
                end
            end
            PH_TLOW:
            begin
                timer_next = timer_reg + 1'b1;
                if (timer_next >= TRIG_LOW_TICKS)
                begin
                    phase_next = PH_THIGH;
                    timer_next = '0;
                end
            end
            PH_THIGH:
            begin
                res_next.trig = 1'b1;
                timer_next    = timer_reg + 1'b1;
                if (timer_next >= TRIG_HIGH_TICKS)
                begin
                    phase_next  = PH_WEND;
                    timer_next  = '0;
                    sub_cm_next = '0;
                    cm_next     = '0;
                end
            end
            PH_WEND, PH_WRISE, PH_MEAS:
            begin
                if (timer_reg >= echo_to_reg)
                begin
                    res_next.done_res = 1'b1;
                    res_next.no_echo  = 1'b1;
                    phase_next        = PH_IDLE;
                    timer_next        = '0;
                end
                else
                begin
                    timer_next = timer_reg + 1'b1;
                    if (phase_reg == PH_WEND)
                    begin
                        if (!samples.data.echo)
                            phase_next = PH_WRISE;
                    end
                    else if (phase_reg == PH_WRISE && !samples.data.echo)
                    begin
                        phase_next = PH_WRISE;
                    end
                    else if (samples.data.echo)
                    begin
                        phase_next = PH_MEAS;
                        // running divide by 58
                        if (sub_cm_reg == US_PER_CM_LAST)
                        begin
                            sub_cm_next = '0;
                            if (cm_reg != CM_MAX)
                                cm_next = cm_reg + 1'b1;
                        end
                        else
                        begin
                            sub_cm_next = sub_cm_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        res_next.done_res    = 1'b1;
                        res_next.distance_cm = cm_reg;
                        res_next.obstacle    = (cm_reg != '0) && (cm_reg <= threshold_reg);
                        phase_next           = PH_IDLE;
                        timer_next           = '0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (samples.data.start_req)
                begin
                    phase_next = PH_GUARD;
                    timer_next = '0;
                end
            end
        endcase

        res_next.busy_res = (phase_next != PH_IDLE);
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            sub_cm_reg    <= '0;
            cm_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg  <= phase_next;
                timer_reg  <= timer_next;
                sub_cm_reg <= sub_cm_next;
                cm_reg     <= cm_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= res_next;
    end

    // a finished measurement leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.done_res |-> !results.data.busy_res)
        else $error("done result reported busy");

    // result fields other than trig and busy only appear on a done tick
    a_quiet_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.data.done_res |->
            results.data.distance_cm == '0 && !results.data.no_echo
            && !results.data.obstacle)
        else $error("result fields set without done");

    // obstacle needs a real echo with a non-zero distance
    a_obstacle: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.obstacle |->
            !results.data.no_echo && results.data.distance_cm != '0)
        else $error("obstacle flagged without a valid distance");

    // trigger is driven only in the trigger-high phase
    a_trig_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg != PH_THIGH |=> !results.data.trig)
        else $error("trigger driven outside trigger phase");

endmodule

`default_nettype wire

>>> tb/tb_ultrasonic_range_controller.sv
// ----------------------------------------------------------------------------
// tb_ultrasonic_range_controller
// Self-checking bench for the ultrasonic range controller. A short table of
// tick beats walks the guard, trigger, echo wait and measurement phases,
// zero and full-scale timeouts and the obstacle threshold. Random tick
// streams then follow the predicted phase so that most measurements run to
// the end. Every result beat is compared with a local model of the
// sequencer or a pinned table reading under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ultrasonic_range_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import urc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned IDLE_PCT = 29;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned SEGMENTS = 6;
    localparam int unsigned SEGMENT_TICKS = 210;

    // trig, busy, done, distance, no_echo, obstacle
    localparam result_t READ_IDLE    = result_t'{1'b0, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0};
    localparam result_t READ_BUSY    = result_t'{1'b0, 1'b1, 1'b0, 11'd0, 1'b0, 1'b0};
    localparam result_t READ_TIMEOUT = result_t'{1'b0, 1'b0, 1'b1, 11'd0, 1'b1, 1'b0};

    typedef enum logic [0:0] {
        ROW_TICK = 1'b0,
        ROW_REG  = 1'b1
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic                  start_req;
        logic                  echo;
        int unsigned           reps;
        bit                    fixed;
        result_t               want;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    urc_sample_if sample_ch ();
    urc_result_if result_ch ();

    ultrasonic_range_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .results   (result_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // local copy of the sequencer and its registers
    phase_t                rc_phase;
    logic [TIMEOUT_W-1:0]  rc_timer;
    logic [SUBCM_W-1:0]    rc_subcm;
    logic [THRESH_W-1:0]   rc_cm;
    logic [THRESH_W-1:0]   thresh_reg;
    logic [TIMEOUT_W-1:0]  guard_reg;
    logic [TIMEOUT_W-1:0]  echo_reg;

    result_t     readings_due[$];
    plan_row_t   plan[$];
    bit          pinned;
    result_t     pinned_reading;
    result_t     due_reading;
    result_t     next_guess;
    int unsigned pulse_left;
    int unsigned errors;
    int unsigned ticks_seen;
    int unsigned measurements;
    int unsigned no_echo_seen;
    int unsigned obstacles_seen;
    int unsigned reg_writes;
    bit          calm;
    logic        hold_start;
    bit          hold_used;
    int          hold_left;

    task automatic count_high_tick();
        if (rc_subcm == US_PER_CM_LAST)
        begin
            rc_subcm = '0;
            if (rc_cm != CM_MAX)
                rc_cm++;
        end
        else
            rc_subcm++;
    endtask

    task automatic next_reading(input sample_t s, output result_t r);
        r = '0;
        case (rc_phase)
            PH_GUARD:
            begin
                if (!s.echo || rc_timer >= guard_reg)
                begin
                    rc_phase = PH_TLOW;
                    rc_timer = '0;
                end
                else
                    rc_timer++;
            end
            PH_TLOW:
            begin
                rc_timer++;
                if (rc_timer >= TRIG_LOW_TICKS)
                begin
                    rc_phase = PH_THIGH;
                    rc_timer = '0;
                end
            end
            PH_THIGH:
            begin
                r.trig = 1'b1;
                rc_timer++;
                if (rc_timer >= TRIG_HIGH_TICKS)
                begin
                    rc_phase = PH_WEND;
                    rc_timer = '0;
                    rc_subcm = '0;
                    rc_cm = '0;
                end
            end
            PH_WEND, PH_WRISE, PH_MEAS:
            begin
                // the timeout wins even over a pulse still in progress
                if (rc_timer >= echo_reg)
                begin
                    r.done_res = 1'b1;
                    r.no_echo = 1'b1;
                    rc_phase = PH_IDLE;
                    rc_timer = '0;
                end
                else
                begin
                    rc_timer++;
                    if (rc_phase == PH_WEND)
                    begin
                        if (!s.echo)
                            rc_phase = PH_WRISE;
                    end
                    else if (rc_phase == PH_WRISE)
                    begin
                        if (s.echo)
                        begin
                            rc_phase = PH_MEAS;
                            count_high_tick();
                        end
                    end
                    else if (s.echo)
                        count_high_tick();
                    else
                    begin
                        r.done_res = 1'b1;
                        r.distance_cm = rc_cm;
                        r.obstacle = (rc_cm != '0) && (rc_cm <= thresh_reg);
                        rc_phase = PH_IDLE;
                        rc_timer = '0;
                    end
                end
            end
            default:
            begin
                rc_phase = PH_IDLE;
                if (s.start_req)
                begin
                    rc_phase = PH_GUARD;
                    rc_timer = '0;
                end
            end
        endcase
        r.busy_res = (rc_phase != PH_IDLE);
    endtask

    task automatic check_reading(input result_t want, input result_t got);
        if (got.trig !== want.trig)
        begin
            $error("trig: expected %0d, got %0d", want.trig, got.trig);
            errors++;
        end
        if (got.busy_res !== want.busy_res)
        begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
            errors++;
        end
        if (got.done_res !== want.done_res)
        begin
            $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
            errors++;
        end
        if (got.distance_cm !== want.distance_cm)
        begin
            $error("distance_cm: expected %0d, got %0d", want.distance_cm, got.distance_cm);
            errors++;
        end
        if (got.no_echo !== want.no_echo)
        begin
            $error("no_echo: expected %0d, got %0d", want.no_echo, got.no_echo);
            errors++;
        end
        if (got.obstacle !== want.obstacle)
        begin
            $error("obstacle: expected %0d, got %0d", want.obstacle, got.obstacle);
            errors++;
        end
    endtask

    // result beats are matched before the sample beat of the same edge is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("result beat with no reading due");
                    errors++;
                end
                else
                begin
                    due_reading = readings_due.pop_front();
                    check_reading(due_reading, result_ch.data);
                    if (due_reading.done_res)
                        measurements++;
                    if (due_reading.no_echo)
                        no_echo_seen++;
                    if (due_reading.obstacle)
                        obstacles_seen++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_THRESHOLD: thresh_reg = cfg_data[THRESH_W-1:0];
                    CFG_GUARD:     guard_reg = cfg_data;
                    CFG_ECHO:      echo_reg = cfg_data;
                    default:       ;
                endcase
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                next_reading(sample_ch.data, next_guess);
                if (pinned)
                    next_guess = pinned_reading;
                readings_due.push_back(next_guess);
                ticks_seen++;
            end
        end
    end

    // result side: random back-pressure, one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_start && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (calm)
            result_ch.ready <= 1'b1;
        else
            result_ch.ready <= ($urandom_range(99, 0) >= IDLE_PCT);
    end

    function automatic void add_ticks(input logic s, input logic e, input int unsigned n,
                                      input bit fix = 1'b0, input result_t want = '0);
        plan_row_t row;
        row.kind = ROW_TICK;
        row.start_req = s;
        row.echo = e;
        row.reps = n;
        row.fixed = fix;
        row.want = want;
        row.idx = '0;
        row.value = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
        plan_row_t row;
        row.kind = ROW_REG;
        row.start_req = 1'b0;
        row.echo = 1'b0;
        row.reps = 0;
        row.fixed = 1'b0;
        row.want = '0;
        row.idx = idx;
        row.value = value;
        plan.push_back(row);
    endfunction

    function automatic int unsigned pulse_width();
        case ($urandom_range(9, 0))
            0:       return 57;
            1:       return 58;
            2:       return $urandom_range(20, 1);
            3:       return 116;
            4, 5, 6: return $urandom_range(300, 1);
            7:       return $urandom_range(1200, 300);
            8:       return 58 * $urandom_range(6, 1) - 1;
            default: return $urandom_range(180, 59);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_timeout();
        case ($urandom_range(4, 0))
            0:       return '0;
            1:       return 16'($urandom_range(40, 1));
            2:       return 16'($urandom_range(2000, 100));
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(65535, 0));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        case ($urandom_range(3, 0))
            0:       return '0;
            1:       return 16'd1129;
            2:       return 16'($urandom_range(30, 0));
            default: return 16'($urandom_range(1129, 0));
        endcase
    endfunction

    // mostly follows the predicted phase so that measurements complete
    task automatic pick_sample(output logic s, output logic e);
        s = 1'($urandom_range(1, 0));
        e = 1'($urandom_range(1, 0));
        if ($urandom_range(99, 0) < 8)
            return;
        case (rc_phase)
            PH_IDLE:
            begin
                s = ($urandom_range(99, 0) < 60);
                e = ($urandom_range(99, 0) < 30);
            end
            PH_GUARD, PH_WEND:
                e = ($urandom_range(99, 0) < 50);
            PH_TLOW, PH_THIGH:
                e = ($urandom_range(99, 0) < 20);
            PH_WRISE:
            begin
                e = ($urandom_range(99, 0) < 20);
                if (e)
                    pulse_left = pulse_width() - 1;
            end
            default:
            begin
                e = (pulse_left != 0);
                if (pulse_left != 0)
                    pulse_left--;
            end
        endcase
    endtask

    // called and returns at a falling edge
    task automatic send_tick(input logic s, input logic e, input bit fix, input result_t want);
        while (!calm && $urandom_range(99, 0) < IDLE_PCT)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pinned = fix;
        pinned_reading = want;
        sample_ch.valid <= 1'b1;
        sample_ch.data <= sample_t'{start_req: s, echo: e};
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    initial
    begin : stimulus
        plan_row_t   row;
        logic        s;
        logic        e;
        int unsigned n;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        result_ch.ready = 1'b0;
        pinned = 1'b0;
        pinned_reading = '0;
        calm = 1'b0;
        hold_start = 1'b0;
        hold_used = 1'b0;
        hold_left = 0;
        pulse_left = 0;
        errors = 0;
        ticks_seen = 0;
        measurements = 0;
        no_echo_seen = 0;
        obstacles_seen = 0;
        reg_writes = 0;
        rc_phase = PH_IDLE;
        rc_timer = '0;
        rc_subcm = '0;
        rc_cm = '0;
        thresh_reg = THRESHOLD_RESET;
        guard_reg = GUARD_RESET;
        echo_reg = ECHO_RESET;

        // reset registers: threshold 0, guard 2000, echo 20000
        add_ticks(1'b0, 1'b0, 1, 1'b1, READ_IDLE);
        add_ticks(1'b0, 1'b1, 1, 1'b1, READ_IDLE);
        add_ticks(1'b1, 1'b1, 1, 1'b1, READ_BUSY);     // start tick only enters guard
        add_ticks(1'b0, 1'b1, 3);                      // guard holds while echo high
        add_ticks(1'b1, 1'b0, 1, 1'b1, READ_BUSY);     // echo low leaves guard, start ignored
        add_ticks(1'b0, 1'b0, 2);
        add_ticks(1'b0, 1'b1, 10);                     // trigger high
        add_ticks(1'b0, 1'b1, 4);                      // old echo still high
        add_ticks(1'b0, 1'b0, 3);
        add_ticks(1'b0, 1'b1, 116);                    // two centimetres, threshold 0
        add_ticks(1'b0, 1'b0, 1);
        // full threshold, zero timeouts, index past the last register
        add_reg(CFG_THRESHOLD, 16'd1129);
        add_reg(CFG_GUARD, 16'd0);
        add_reg(CFG_ECHO, 16'd0);
        add_reg(CFG_UNUSED, 16'hFFFF);
        add_ticks(1'b1, 1'b1, 1, 1'b1, READ_BUSY);
        add_ticks(1'b0, 1'b1, 1, 1'b1, READ_BUSY);     // guard gives up at once
        add_ticks(1'b0, 1'b1, 12);
        add_ticks(1'b0, 1'b1, 1, 1'b1, READ_TIMEOUT);  // zero echo timeout
        // full-scale timeouts, obstacle boundary
        add_reg(CFG_THRESHOLD, 16'd2);
        add_reg(CFG_GUARD, 16'hFFFF);
        add_reg(CFG_ECHO, 16'hFFFF);
        add_ticks(1'b1, 1'b0, 1, 1'b1, READ_BUSY);
        add_ticks(1'b0, 1'b0, 15);
        add_ticks(1'b0, 1'b1, 57);                     // short pulse, distance 0
        add_ticks(1'b0, 1'b0, 1);
        add_ticks(1'b1, 1'b0, 16);
        add_ticks(1'b0, 1'b1, 116);                    // distance equal to threshold
        add_ticks(1'b0, 1'b0, 1);
        // echo timeout while the pulse is still high
        add_reg(CFG_ECHO, 16'd100);
        add_ticks(1'b1, 1'b0, 16);
        add_ticks(1'b0, 1'b1, 150);
        add_ticks(1'b0, 1'b0, 1, 1'b1, READ_IDLE);

        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[k])
        begin
            row = plan[k];
            if (row.kind == ROW_REG)
            begin
                settle();
                write_reg(row.idx, row.value);
            end
            else
            begin
                for (n = 0; n < row.reps; n++)
                    send_tick(row.start_req, row.echo, row.fixed, row.want);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            settle();
            calm = (seg == 0);
            case (seg)
                0:
                begin
                    write_reg(CFG_THRESHOLD, 16'd1129);
                    write_reg(CFG_GUARD, 16'd0);
                    write_reg(CFG_ECHO, 16'hFFFF);
                end
                1:
                begin
                    write_reg(CFG_THRESHOLD, 16'd0);
                    write_reg(CFG_GUARD, 16'hFFFF);
                    write_reg(CFG_ECHO, 16'd0);
                end
                default:
                begin
                    write_reg(CFG_THRESHOLD, pick_threshold());
                    write_reg(CFG_GUARD, pick_timeout());
                    write_reg(CFG_ECHO, pick_timeout());
                end
            endcase
            write_reg(CFG_UNUSED, 16'($urandom_range(65535, 0)));
            for (n = 0; n < SEGMENT_TICKS; n++)
            begin
                // results stay unread for a while so the sample side backs up
                if (seg == 3 && n == 100)
                    hold_start <= 1'b1;
                pick_sample(s, e);
                send_tick(s, e, 1'b0, '0);
            end
        end

        sample_ch.valid <= 1'b0;
        for (n = 0; n < 2000 && readings_due.size() != 0; n++)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        if (readings_due.size() != 0)
        begin
            $error("%0d readings never arrived", readings_due.size());
            errors++;
        end

        $display("%0d ticks checked, %0d measurements ended (%0d without echo, %0d obstacles)",
                 ticks_seen, measurements, no_echo_seen, obstacles_seen);
        $display("%0d register writes over zero and full-scale timeouts and thresholds",
                 reg_writes);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("run timed out");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
design/urc_pkg.sv
design/urc_if.sv
design/ultrasonic_range_controller.sv
tb/tb_ultrasonic_range_controller.sv
